// ===== src/assert_macros.svh =====
// Assertion helpers shared by the top module and the digit stack.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// expr must never be true at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

// ===== src/i2a_pkg.sv =====
`default_nettype none

package i2a_pkg;

    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int STORE_DEPTH = 10;     // "4294967295" / "2147483648" need ten digits

    // floor(n / 10) == (n * RECIP_10) >> RECIP_SHIFT for every 32-bit n
    localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;   // '-'

    typedef struct packed {
        logic mul_en;   // capture mag * reciprocal
        logic hex;      // divide by 16 instead of 10
    } div_ctl_t;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic [DIGIT_W-1:0] digit;
    } stk_ctl_t;

    typedef struct packed {
        logic empty;
        logic one_left;
        logic full;
    } stk_stat_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = 8'h30 + {4'h0, d};                  // '0'..'9'
        end else begin
            c = 8'h61 + {4'h0, d} - 8'd10;          // 'a'..'f'
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/int_to_ascii_dec_hex.sv =====
// int_to_ascii_dec_hex: one 32-bit word in, its ASCII text out, one item per character.
// Input channel s_*: s_tdata = value, s_tuser = mode (0 signed decimal, 1 lower-case hex).
// Output channel m_*: m_tdata = character, m_tlast high on the final character.
// Decimal: '-' first for negative words, then the magnitude digits, most significant first,
// no leading zeros; 0x80000000 gives "-2147483648". Zero gives a single '0'.
// Hex: the word is unsigned, 1 to 8 digits, no sign.
// Timing: s_tready is high only while idle. After an item is taken the shared divide unit
// makes each decimal digit by a reciprocal multiply, then a remainder step, and one digit per
// cycle in hex; then characters leave at one per cycle when m_tready is held high.
// The input goes ready again in the cycle the last character is loaded into the output
// register, so the next item is taken while that character still waits.
// Receiver stall: the output register holds its item and the sequencer waits; nothing drops.
// Reset (aresetn low, synchronous) empties the digit store and the output register and
// returns to idle; the digit entries themselves are not cleared.
`default_nettype none

`include "assert_macros.svh"

module int_to_ascii_dec_hex
    import i2a_pkg::*;
#(
    parameter int DIGIT_DEPTH = STORE_DEPTH
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // input items
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [VALUE_W-1:0]  s_tdata,    // [31:0] value
    input  wire logic                s_tuser,    // [0] opcode
    // result items
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [CHAR_W-1:0]   m_tdata,    // [7:0] char_out
    output logic                     m_tlast     // last
);

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,   // waiting for an item
        S_MUL  = 4'b0010,   // decimal: reciprocal product being registered
        S_DIV  = 4'b0100,   // quotient/remainder ready, push one digit
        S_EMIT = 4'b1000    // stream sign and digits
    } state_t;

    state_t             state_reg, state_next;
    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic               hex_reg, hex_next;
    logic               sign_reg, sign_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]  m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;

    div_ctl_t           div_ctl;
    logic [VALUE_W-1:0] quot;
    logic [DIGIT_W-1:0] rem;

    stk_ctl_t           stk_ctl;
    stk_stat_t          stk_stat;
    logic [DIGIT_W-1:0] top_digit;

    logic               out_free;
    logic               in_neg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // output register can take a new character
    assign out_free = !m_tvalid_reg || m_tready;
    assign in_neg   = !s_tuser && s_tdata[VALUE_W-1];

    assign div_ctl.mul_en = (state_reg == S_MUL);
    assign div_ctl.hex    = hex_reg;

    i2a_radix_div u_div (
        .aclk (aclk),
        .ctl  (div_ctl),
        .mag  (mag_reg),
        .quot (quot),
        .rem  (rem)
    );

    i2a_digit_stack #(
        .DEPTH (DIGIT_DEPTH)
    ) u_stack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (stk_ctl),
        .stat      (stk_stat),
        .top_digit (top_digit)
    );

    always_comb begin
        state_next    = state_reg;
        mag_next      = mag_reg;
        hex_next      = hex_reg;
        sign_next     = sign_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        stk_ctl       = '0;
        stk_ctl.digit = rem;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    // magnitude by unsigned negation: most negative value stays exact
                    mag_next   = in_neg ? (VALUE_W'(0) - s_tdata) : s_tdata;
                    hex_next   = s_tuser;
                    sign_next  = in_neg;
                    state_next = s_tuser ? S_DIV : S_MUL;
                end
            end
            S_MUL: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                stk_ctl.push = 1'b1;
                mag_next     = quot;
                if (quot == '0) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = hex_reg ? S_DIV : S_MUL;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (sign_reg) begin
                        m_tdata_next = CHAR_MINUS;
                        m_tlast_next = 1'b0;
                        sign_next    = 1'b0;
                    end else begin
                        stk_ctl.pop  = 1'b1;
                        m_tdata_next = digit_char(top_digit);
                        m_tlast_next = stk_stat.one_left;
                        if (stk_stat.one_left) begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            sign_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sign_reg     <= sign_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg     <= mag_next;
        hex_reg     <= hex_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    // store must hold at least one digit whenever characters are being sent
    `ASSERT_NEVER(a_emit_nonempty, aclk, aresetn, (state_reg == S_EMIT) && stk_stat.empty, "emit with empty digit store")
    // a taken item keeps the input closed on the next cycle
    `ASSERT_PROP(a_busy_after_accept, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "input ready straight after accept")
    // the sign is never the final character
    `ASSERT_NEVER(a_sign_not_last, aclk, aresetn, m_tvalid_reg && m_tlast_reg && (m_tdata_reg == CHAR_MINUS), "sign flagged last")
    // no leftover digits when a new item starts
    `ASSERT_NEVER(a_idle_empty, aclk, aresetn, (state_reg == S_IDLE) && !stk_stat.empty, "digits left over at idle")

endmodule

`default_nettype wire

// ===== src/i2a_radix_div.sv =====
`default_nettype none

// Shared divide-by-radix step: quotient and remainder of mag by 10 or 16.
// Decimal uses a registered reciprocal product, so mul_en must be high in the cycle before.
module i2a_radix_div
    import i2a_pkg::*;
(
    input  wire logic               aclk,
    input  wire div_ctl_t           ctl,
    input  wire logic [VALUE_W-1:0] mag,
    output logic      [VALUE_W-1:0] quot,
    output logic      [DIGIT_W-1:0] rem
);

    logic [2*VALUE_W-1:0] product_reg;
    logic [VALUE_W-1:0]   q_dec;
    logic [VALUE_W-1:0]   q_times10;

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            product_reg <= {{VALUE_W{1'b0}}, mag} * {{VALUE_W{1'b0}}, RECIP_10};
        end
    end

    assign q_dec     = VALUE_W'(product_reg >> RECIP_SHIFT);
    assign q_times10 = (q_dec << 3) + (q_dec << 1);

    always_comb begin
        if (ctl.hex) begin
            quot = mag >> DIGIT_W;
            rem  = mag[DIGIT_W-1:0];
        end else begin
            quot = q_dec;
            rem  = DIGIT_W'(mag - q_times10);
        end
    end

endmodule

`default_nettype wire

// ===== src/i2a_digit_stack.sv =====
`default_nettype none

`include "assert_macros.svh"

// LIFO of digit values: filled least significant first, drained from the top.
module i2a_digit_stack
    import i2a_pkg::*;
#(
    parameter int DEPTH = STORE_DEPTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire stk_ctl_t           ctl,
    output stk_stat_t               stat,
    output logic      [DIGIT_W-1:0] top_digit
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DIGIT_W-1:0] mem [DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   top_pos;

    assign top_pos   = count_reg - CNT_W'(1);
    assign top_digit = mem[top_pos[IDX_W-1:0]];

    assign stat.empty    = (count_reg == '0);
    assign stat.one_left = (count_reg == CNT_W'(1));
    assign stat.full     = (count_reg == CNT_W'(DEPTH));

    always_comb begin
        count_next = count_reg;
        if (ctl.push && !stat.full) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctl.pop && !stat.empty) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push && !stat.full) begin
            mem[count_reg[IDX_W-1:0]] <= ctl.digit;
        end
    end

    `ASSERT_NEVER(a_push_full, aclk, aresetn, ctl.push && stat.full, "digit push while full")
    `ASSERT_NEVER(a_pop_empty, aclk, aresetn, ctl.pop && stat.empty, "digit pop while empty")
    `ASSERT_NEVER(a_push_pop, aclk, aresetn, ctl.push && ctl.pop, "push and pop together")

endmodule

`default_nettype wire

// ===== dv/int_to_ascii_dec_hex_tb.sv =====
`timescale 1ns / 1ps

// Conversion mode as carried on s_tuser
typedef enum logic {
    MODE_DEC = 1'b0,
    MODE_HEX = 1'b1
} conv_mode_e;

// Expected text of each accepted word, kept as a queue of characters
class ascii_scoreboard;
    typedef struct packed {
        logic [i2a_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } char_t;

    char_t pending_chars[$];
    string glyphs = "0123456789abcdef";
    int    errors;
    int    dec_words;
    int    hex_words;
    int    chars_seen;

    // Work out the characters one accepted word must produce
    function void predict_text(logic [i2a_pkg::VALUE_W-1:0] word, conv_mode_e mode);
        logic [i2a_pkg::VALUE_W-1:0] mag;
        logic [i2a_pkg::VALUE_W-1:0] radix;
        logic [3:0]                  digit;
        logic [3:0]                  digits[$];
        char_t                       c;
        mag   = word;
        radix = (mode == MODE_HEX) ? 32'd16 : 32'd10;
        if (mode == MODE_HEX) begin
            hex_words++;
        end else begin
            dec_words++;
        end
        if (mode == MODE_DEC && word[31]) begin
            mag    = 32'd0 - word;       // also right for 0x80000000
            c.ch   = i2a_pkg::CHAR_MINUS;
            c.last = 1'b0;
            pending_chars.push_back(c);
        end
        do begin
            digit = 4'(mag % radix);
            digits.push_front(digit);
            mag = mag / radix;
        end while (mag != 0);
        foreach (digits[i]) begin
            c.ch   = glyphs[digits[i]];
            c.last = (i == digits.size() - 1);
            pending_chars.push_back(c);
        end
    endfunction

    function void check_char(logic [i2a_pkg::CHAR_W-1:0] ch, logic last);
        char_t want;
        if (pending_chars.size() == 0) begin
            $error("unexpected character %h (last %b) with nothing pending", ch, last);
            errors++;
            return;
        end
        want = pending_chars.pop_front();
        chars_seen++;
        if (ch !== want.ch) begin
            $error("char_out: expected %h, actual %h", want.ch, ch);
            errors++;
        end
        if (last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, last);
            errors++;
        end
    endfunction

    function int pending();
        return pending_chars.size();
    endfunction
endclass

module int_to_ascii_dec_hex_tb;
    import i2a_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on either side
    localparam int HOLD_OFF       = 300;   // long receiver stall for the back-pressure phase
    localparam int DRAIN_CYCLES   = 40;    // wait after the last expected character, for strays
    localparam int PHASE_ITEMS    = 80;
    localparam int PRESSURE_ITEMS = 30;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata  = '0;
    logic               s_tuser  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [CHAR_W-1:0]  m_tdata;
    logic               m_tlast;

    // Percentages for sender idling and receiver stalls, set per phase
    int idle_pct  = 0;
    int stall_pct = 0;
    // Hold-off request from the stimulus, and the count-down owned by the receiver
    int hold_len  = 0;
    int hold_left = 0;

    ascii_scoreboard sb = new();

    int_to_ascii_dec_hex uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_len > 0) begin
            hold_left = hold_len;
            hold_len  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor: words are noted before characters are checked, so an item taken and a
    // character leaving on the same edge are always seen in order.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.predict_text(s_tdata, conv_mode_e'(s_tuser));
            end
            if (m_tvalid && m_tready) begin
                sb.check_char(m_tdata, m_tlast);
            end
        end
    end

    // Watchdog: a run of cycles with no item moving either way ends the test
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no handshake for %0d cycles, %0d characters outstanding",
                 WATCHDOG_LIMIT, sb.pending());
        $display("Test completed with failures");
        $finish;
    end

    // Offer one word and wait until the block takes it. Valid stays high afterwards;
    // the gap task lowers it only when an idle stretch follows.
    task automatic push_word(input logic [VALUE_W-1:0] v, input conv_mode_e mode);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= mode;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    // Sender idle cycles after an item, geometric in length
    task automatic sender_gap();
        int n;
        n = 0;
        while ($urandom_range(99) < idle_pct) begin
            n++;
        end
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_word(input logic [VALUE_W-1:0] v, input conv_mode_e mode);
        push_word(v, mode);
        sender_gap();
    endtask

    // Random word: mostly short magnitudes so that every digit count turns up,
    // half of the decimal ones negated, plus the odd corner value
    function automatic logic [VALUE_W-1:0] random_word(conv_mode_e mode);
        logic [VALUE_W-1:0] v;
        int                 width;
        v     = $urandom();
        width = $urandom_range(32, 1);
        v     = v >> (32 - width);
        if (mode == MODE_DEC && $urandom_range(1) == 1) begin
            v = 32'd0 - v;
        end
        case ($urandom_range(24))
            0: v = 32'h0000_0000;
            1: v = 32'h8000_0000;
            2: v = 32'hFFFF_FFFF;
            3: v = 32'h7FFF_FFFF;
            default: ;
        endcase
        return v;
    endfunction

    task automatic random_items(input int count);
        conv_mode_e mode;
        for (int i = 0; i < count; i++) begin
            mode = conv_mode_e'($urandom_range(1));
            send_word(random_word(mode), mode);
        end
    endtask

    initial begin
        // Reset held low from the start, released on a rising edge
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero, single digits, digit-count boundaries, both signs,
        // the most negative word, and hex words with the top bit set
        send_word(32'd0,          MODE_DEC);
        send_word(32'd0,          MODE_HEX);
        send_word(32'd7,          MODE_DEC);
        send_word(32'd9,          MODE_DEC);
        send_word(32'd10,         MODE_DEC);
        send_word(32'hFFFF_FFFF,  MODE_DEC);   // -1
        send_word(32'hFFFF_FFF6,  MODE_DEC);   // -10
        send_word(32'h7FFF_FFFF,  MODE_DEC);
        send_word(32'h8000_0000,  MODE_DEC);   // eleven characters
        send_word(32'h8000_0001,  MODE_DEC);
        send_word(32'd999999999,  MODE_DEC);
        send_word(32'd1000000000, MODE_DEC);
        send_word(32'h0000_000F,  MODE_HEX);
        send_word(32'h0000_0010,  MODE_HEX);
        send_word(32'h7FFF_FFFF,  MODE_HEX);
        send_word(32'h8000_0000,  MODE_HEX);
        send_word(32'hFFFF_FFFF,  MODE_HEX);
        send_word(32'hDEAD_BEEF,  MODE_HEX);
        send_word(32'h0123_4567,  MODE_HEX);
        send_word(32'h89AB_CDEF,  MODE_HEX);
        send_word(32'h1000_0000,  MODE_HEX);

        // Random phases: free flow, sender idling, receiver stalling, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 74; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 74; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            random_items(PHASE_ITEMS);
        end

        // Back-pressure: receiver holds off for a long stretch while words keep
        // coming, so the output register fills and the block stops taking input
        idle_pct  = 0;
        stall_pct = 0;
        hold_len  = HOLD_OFF;
        random_items(PRESSURE_ITEMS);
        s_tvalid <= 1'b0;

        // Drain, then give any stray character time to show
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Converted %0d words (%0d decimal, %0d hex) into %0d characters,",
                 sb.dec_words + sb.hex_words, sb.dec_words, sb.hex_words, sb.chars_seen);
        $display("under free flow, sender gaps, receiver stalls and a long hold-off.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/i2a_pkg.sv
src/i2a_radix_div.sv
src/i2a_digit_stack.sv
src/int_to_ascii_dec_hex.sv
dv/int_to_ascii_dec_hex_tb.sv
